// ===== hdl/six_channel_moving_average_calibrate_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the six-channel moving average block
// Shared helpers that clock on clk and are disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SIX_CHANNEL_MOVING_AVERAGE_CALIBRATE_DEFINES_SVH
`define SIX_CHANNEL_MOVING_AVERAGE_CALIBRATE_DEFINES_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define SCMA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define SCMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/scma_pkg.sv =====
// ---------------------------------------------------------------------------
// scma_pkg
// Widths, calibration constants and lane control type for the averager.
// ---------------------------------------------------------------------------
package scma_pkg;

	localparam int CH       = 6;
	localparam int SAMPLE_W = 12;
	localparam int FORCE_W  = 25;
	localparam int GAIN_W   = 16;
	localparam int OFFS_W   = 16;

	// Ring length; any value from 1 to 256
	localparam int WINDOW = 16;

	localparam int LOG_W  = $clog2(WINDOW);
	localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = SAMPLE_W + LOG_W;
	localparam int PROD_W = SUM_W + GAIN_W;
	// Product after the fixed divide by 256
	localparam int X_W    = PROD_W - 8;
	// Exact reciprocal for floor(x / WINDOW) over all x below 2**X_W
	localparam int K_SH   = X_W + LOG_W;
	localparam int M_W    = X_W + 2;
	localparam int T_W    = X_W + M_W;
	localparam int Q_W    = T_W - K_SH;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << K_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [M_W-1:0] RECIP = M_W'(RECIP_FULL);

	typedef logic [SAMPLE_W-1:0]       sample_t;
	typedef logic signed [FORCE_W-1:0] force_t;
	typedef logic [GAIN_W-1:0]         gain_t;
	typedef logic [OFFS_W-1:0]         offs_t;

	// Gains in Q16, offsets in Q8
	localparam gain_t GAIN [CH] = '{
		16'd35062, 16'd6914, 16'd11036, 16'd28869, 16'd4705, 16'd17983
	};
	localparam offs_t OFFSET [CH] = '{
		16'd16370, 16'd1019, 16'd6295, 16'd2242, 16'd5082, 16'd33485
	};

	// Bounds of any force the arithmetic can produce
	localparam force_t FORCE_MIN = -25'sd33485;
	localparam force_t FORCE_MAX = 25'sd560854;

	typedef struct packed {
		logic             accept;
		logic             en2;
		logic             en3;
		logic [POS_W-1:0] wr_addr;
		logic [POS_W-1:0] rd_addr;
		logic             old_valid;
		logic             byp;
	} lane_ctrl_t;

endpackage

// ===== hdl/scma_if.sv =====
// ---------------------------------------------------------------------------
// scma_in_if / scma_out_if
// Valid/ready channels for sample sets and calibrated force sets.
// ---------------------------------------------------------------------------
interface scma_in_if import scma_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t drag_front_sample;
	sample_t drag_back_sample;
	sample_t lift_up_sample;
	sample_t lift_down_sample;
	sample_t side_left_sample;
	sample_t side_right_sample;

	modport source (output valid, output drag_front_sample, output drag_back_sample,
		output lift_up_sample, output lift_down_sample, output side_left_sample,
		output side_right_sample, input ready);
	modport sink (input valid, input drag_front_sample, input drag_back_sample,
		input lift_up_sample, input lift_down_sample, input side_left_sample,
		input side_right_sample, output ready);
endinterface

interface scma_out_if import scma_pkg::*; ();
	logic   valid;
	logic   ready;
	force_t drag_front_force;
	force_t drag_back_force;
	force_t lift_up_force;
	force_t lift_down_force;
	force_t side_left_force;
	force_t side_right_force;

	modport source (output valid, output drag_front_force, output drag_back_force,
		output lift_up_force, output lift_down_force, output side_left_force,
		output side_right_force, input ready);
	modport sink (input valid, input drag_front_force, input drag_back_force,
		input lift_up_force, input lift_down_force, input side_left_force,
		input side_right_force, output ready);
endinterface

// ===== hdl/scma_ram.sv =====
// ---------------------------------------------------------------------------
// scma_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module scma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/scma_ctrl.sv =====
// ---------------------------------------------------------------------------
// scma_ctrl
// Shared ring position, entry valid bits and pipeline stage control.
// ---------------------------------------------------------------------------
module scma_ctrl import scma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       o_take,
	output logic       v3,
	output lane_ctrl_t lane_ctrl
);

	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos_next;
	logic [WINDOW-1:0] valid_q;
	logic              v1_q;
	logic              v2_q;
	logic              v3_q;
	logic              byp_q;
	logic              en1;
	logic              en2;
	logic              en3;
	logic              accept;
	logic [POS_W-1:0]  rd_addr;

	// Stage enables: a stage moves when it is empty or the next one moves
	assign en3      = !v3_q || o_take;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign in_ready = en1;
	assign accept   = in_valid && en1;
	assign v3       = v3_q;

	// Wrap the write position
	assign pos_next = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + POS_W'(1);
	// Prefetch the entry the next transaction will overwrite
	assign rd_addr  = accept ? pos_next : pos_q;

	always_comb begin
		lane_ctrl.accept    = accept;
		lane_ctrl.en2       = en2;
		lane_ctrl.en3       = en3;
		lane_ctrl.wr_addr   = pos_q;
		lane_ctrl.rd_addr   = rd_addr;
		lane_ctrl.old_valid = valid_q[pos_q];
		lane_ctrl.byp       = byp_q;
	end

	// Advance position, mark written entries, move stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			byp_q   <= 1'b0;
		end else begin
			byp_q <= accept && (rd_addr == pos_q);
			if (accept) begin
				pos_q          <= pos_next;
				valid_q[pos_q] <= 1'b1;
			end
			if (en1) begin
				v1_q <= accept;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

endmodule

// ===== hdl/scma_lane.sv =====
// ---------------------------------------------------------------------------
// scma_lane
// One channel: sample ring, running sum, gain multiply and scaling.
// ---------------------------------------------------------------------------
module scma_lane import scma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t lane_ctrl,
	input  sample_t    sample,
	input  gain_t      gain,
	input  offs_t      offset,
	output force_t     force_val
);

	sample_t           rdata;
	sample_t           byp_data_q;
	sample_t           old;
	logic [SUM_W-1:0]  sum_q;
	logic [PROD_W-1:0] prod_s2;
	logic [T_W-1:0]    t_s3;
	logic [X_W-1:0]    x;
	logic [Q_W-1:0]    quot;

	scma_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_ram (
		.clk  (clk),
		.we   (lane_ctrl.accept),
		.waddr(lane_ctrl.wr_addr),
		.wdata(sample),
		.raddr(lane_ctrl.rd_addr),
		.rdata(rdata)
	);

	// Pick the sample leaving the window; unwritten entries count as zero
	always_comb begin
		if (!lane_ctrl.old_valid) begin
			old = '0;
		end else if (lane_ctrl.byp) begin
			old = byp_data_q;
		end else begin
			old = rdata;
		end
	end

	// Update the running sum on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (lane_ctrl.accept) begin
			sum_q <= sum_q - SUM_W'(old) + SUM_W'(sample);
		end
	end

	// Hold the last written sample for a read of the same entry
	always_ff @(posedge clk) begin
		if (lane_ctrl.accept) begin
			byp_data_q <= sample;
		end
	end

	// Scale: sum * gain, then floor divide by 256 * WINDOW
	assign x = prod_s2[PROD_W-1:8];

	always_ff @(posedge clk) begin
		if (lane_ctrl.en2) begin
			prod_s2 <= PROD_W'(sum_q) * PROD_W'(gain);
		end
		if (lane_ctrl.en3) begin
			t_s3 <= T_W'(x) * T_W'(RECIP);
		end
	end

	// Remove the offset
	assign quot      = t_s3[T_W-1:K_SH];
	assign force_val = force_t'({{(FORCE_W - Q_W){1'b0}}, quot}) - force_t'(offset);

endmodule

// ===== hdl/scma_merge.sv =====
// ---------------------------------------------------------------------------
// scma_merge
// Output register that gathers the six lane results into one transaction.
// ---------------------------------------------------------------------------
module scma_merge import scma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       v3,
	input  force_t     force_lane [CH],
	output logic       o_take,
	scma_out_if.source forces
);

	logic   ov_q;
	force_t force_q [CH];

	assign o_take = !ov_q || forces.ready;

	// Load a new result set whenever the register is free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (o_take) begin
			ov_q <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (o_take && v3) begin
			force_q <= force_lane;
		end
	end

	assign forces.valid            = ov_q;
	assign forces.drag_front_force = force_q[0];
	assign forces.drag_back_force  = force_q[1];
	assign forces.lift_up_force    = force_q[2];
	assign forces.lift_down_force  = force_q[3];
	assign forces.side_left_force  = force_q[4];
	assign forces.side_right_force = force_q[5];

endmodule

// ===== hdl/six_channel_moving_average_calibrate.sv =====
// ---------------------------------------------------------------------------
// six_channel_moving_average_calibrate
// Boxcar average of six load-cell channels with per-channel gain and offset.
//
//   channel   direction   payload                    handshake
//   samples   in          six 12-bit ADC counts      valid / ready
//   forces    out         six 25-bit signed, Q8      valid / ready
//
// One transaction per cycle is accepted while ready is high; the running sum
// updates at the accepting edge and the result then passes the gain multiply,
// reciprocal multiply and output registers in that order.
// Reset clears ring valid bits, sums and position; no clearing pass needed.
// Ready drops only when all four stages hold results and forces is stalled.
// ---------------------------------------------------------------------------
module six_channel_moving_average_calibrate import scma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	scma_in_if.sink    samples,
	scma_out_if.source forces
);

	lane_ctrl_t lane_ctrl;
	logic       o_take;
	logic       v3;
	sample_t    samp [CH];
	force_t     force_lane [CH];

	assign samp[0] = samples.drag_front_sample;
	assign samp[1] = samples.drag_back_sample;
	assign samp[2] = samples.lift_up_sample;
	assign samp[3] = samples.lift_down_sample;
	assign samp[4] = samples.side_left_sample;
	assign samp[5] = samples.side_right_sample;

	scma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.o_take   (o_take),
		.v3       (v3),
		.lane_ctrl(lane_ctrl)
	);

	// One lane per load cell
	for (genvar i = 0; i < CH; i++) begin : g_lane
		scma_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.lane_ctrl(lane_ctrl),
			.sample   (samp[i]),
			.gain     (GAIN[i]),
			.offset   (OFFSET[i]),
			.force_val(force_lane[i])
		);
	end

	scma_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.v3        (v3),
		.force_lane(force_lane),
		.o_take    (o_take),
		.forces    (forces)
	);

endmodule

// ===== hdl/scma_check.sv =====
// ---------------------------------------------------------------------------
// scma_check
// Port-level checks on the averager: stall behavior, in-flight count, result range.
// ---------------------------------------------------------------------------
`include "six_channel_moving_average_calibrate_defines.svh"

module scma_check import scma_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input force_t out_front,
	input force_t out_right
);

	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	`SCMA_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "valid dropped")
	`SCMA_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(out_front), "data moved")
	`SCMA_ASSERT_SAME(a_pend_max, 1'b1, pend_q <= 3'd4, "more than four in flight")
	`SCMA_ASSERT_SAME(a_front_range, out_valid, out_front >= FORCE_MIN && out_front <= FORCE_MAX, "range")
	`SCMA_ASSERT_SAME(a_right_range, out_valid, out_right >= FORCE_MIN && out_right <= FORCE_MAX, "range")

endmodule

bind six_channel_moving_average_calibrate scma_check u_scma_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(forces.valid),
	.out_ready(forces.ready),
	.out_front(forces.drag_front_force),
	.out_right(forces.side_right_force)
);
